// ===== hw/rtl/go_back_n_sender_macros.svh =====
// assertion macros for the go-back-n sender
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GBN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("go_back_n_sender assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GBN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("go_back_n_sender assertion failed");

`endif

// ===== hw/rtl/gbn_pkg.sv =====
// shared types and constants for the go-back-n sender
package gbn_pkg;

  localparam int SEQ_SPACE_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [2:0] WIN_SIZE_RST = 3'd4;

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_t;

  typedef enum logic [0:0] {
    OP_SUB = 1'b0,
    OP_INC = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_EVAL    = 3'd1,
    ST_SEND    = 3'd2,
    ST_ACK_CHK = 3'd3,
    ST_ACK_UPD = 3'd4,
    ST_TO_RD   = 3'd5,
    ST_TO_EMIT = 3'd6
  } state_t;

  typedef struct packed {
    logic        accepted;
    logic        packet_valid;
    logic [2:0]  packet_seq;
    logic [31:0] packet_payload;
    timer_t      timer_action;
    logic        window_full;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/gbn_ram.sv =====
// generic one-write one-read ram with registered read data
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/gbn_modunit.sv =====
// shared modular subtract / increment unit over the sequence space
module gbn_modunit #(
  parameter int SEQ_SPACE = gbn_pkg::SEQ_SPACE_DEF
) (
  input  gbn_pkg::op_t                 op,
  input  logic [$clog2(SEQ_SPACE)-1:0] a,
  input  logic [$clog2(SEQ_SPACE)-1:0] b,
  output logic [$clog2(SEQ_SPACE)-1:0] y
);

  localparam int SEQ_W = $clog2(SEQ_SPACE);

  logic [SEQ_W:0] diff;
  logic [SEQ_W:0] diff_wrap;

  always_comb begin
    diff      = {1'b0, a} - {1'b0, b};
    diff_wrap = diff + (SEQ_W+1)'(SEQ_SPACE);
    case (op)
      gbn_pkg::OP_SUB: begin
        y = diff[SEQ_W] ? diff_wrap[SEQ_W-1:0] : diff[SEQ_W-1:0];
      end
      gbn_pkg::OP_INC: begin
        y = (a == SEQ_W'(SEQ_SPACE - 1)) ? '0 : a + SEQ_W'(1);
      end
      default: begin
        y = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/go_back_n_sender.sv =====
// go-back-n sender: window state, payload buffer ram and sequencer
// a result is registered from the state that settles it: EVAL for refused, ignored and empty-window items,
// SEND for send, ACK_CHK or ACK_UPD for ack, and one TO_EMIT per resent packet after its TO_RD
// busy stays high until the item ends, so a new start is taken only once the last item is through;
// each step is one pass of the shared modulo unit and retransmit waits on the ram read
// reset (rst_n low, synchronous): empty window, base and next at 0, window size 4
module go_back_n_sender #(
  parameter int SEQ_SPACE    = gbn_pkg::SEQ_SPACE_DEF,
  parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_payload,
  input  logic [2:0]  in_ack_number,
  input  logic        in_ack_checksum_ok,
  output logic        out_valid,
  output logic        out_accepted,
  output logic        out_packet_valid,
  output logic [2:0]  out_packet_seq,
  output logic [31:0] out_packet_payload,
  output logic [1:0]  out_timer_action,
  output logic        out_window_full,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_window_size
);

  `include "go_back_n_sender_macros.svh"

  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam logic [7:0] WIN_CAP = 8'(SEQ_SPACE - 1);

  gbn_pkg::state_t state_r, state_nxt;

  logic [SEQ_W-1:0]        base_r, base_nxt;
  logic [SEQ_W-1:0]        next_r, next_nxt;
  logic [2:0]              wsize_r;
  logic [1:0]              cmd_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [2:0]              ack_r;
  logic                    ok_r;
  logic [SEQ_W-1:0]        cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]        dist_r, dist_nxt;
  logic [SEQ_W-1:0]        ptr_r, ptr_nxt;
  logic [SEQ_W-1:0]        seq_r, seq_nxt;
  logic [SEQ_W-1:0]        rem_r, rem_nxt;
  logic                    first_r, first_nxt;
  logic                    out_valid_r;
  gbn_pkg::res_t           out_res_r;

  gbn_pkg::op_t            unit_op;
  logic [SEQ_W-1:0]        unit_a, unit_b, unit_y;

  logic                    ram_we, ram_re;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  logic                    emit;
  gbn_pkg::res_t           res;

  logic [7:0]              eff_w;
  logic                    full_now, full_cur, ack_bad;
  logic [SEQ_W-1:0]        ack_seq, newcnt;
  logic [63:0]             in_wide, pay_wide, rd_wide;

  gbn_modunit #(.SEQ_SPACE(SEQ_SPACE)) u_unit (
    .op(unit_op),
    .a (unit_a),
    .b (unit_b),
    .y (unit_y)
  );

  gbn_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SEQ_SPACE)) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(next_r),
    .wdata(pay_r),
    .re   (ram_re),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  assign busy      = (state_r != gbn_pkg::ST_IDLE);
  assign cfg_ready = (state_r == gbn_pkg::ST_IDLE);

  assign in_wide  = 64'(in_payload);
  assign pay_wide = 64'(pay_r);
  assign rd_wide  = 64'(ram_rdata);

  assign eff_w    = (8'(wsize_r) > WIN_CAP) ? WIN_CAP : 8'(wsize_r);
  assign full_now = (8'(unit_y) >= eff_w);
  assign full_cur = (8'(cnt_r) >= eff_w);
  assign ack_seq  = SEQ_W'(ack_r);
  assign ack_bad  = !ok_r || (8'(ack_r) >= 8'(SEQ_SPACE)) || (unit_y >= cnt_r);
  assign newcnt   = cnt_r - dist_r - SEQ_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbn_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = gbn_pkg::ST_EVAL;
        end
      end
      gbn_pkg::ST_EVAL: begin
        case (cmd_r)
          gbn_pkg::CMD_SEND:    state_nxt = full_now ? gbn_pkg::ST_IDLE : gbn_pkg::ST_SEND;
          gbn_pkg::CMD_ACK:     state_nxt = gbn_pkg::ST_ACK_CHK;
          gbn_pkg::CMD_TIMEOUT: state_nxt = (unit_y == '0) ? gbn_pkg::ST_IDLE
                                                           : gbn_pkg::ST_TO_RD;
          default:              state_nxt = gbn_pkg::ST_IDLE;
        endcase
      end
      gbn_pkg::ST_SEND:    state_nxt = gbn_pkg::ST_IDLE;
      gbn_pkg::ST_ACK_CHK: state_nxt = ack_bad ? gbn_pkg::ST_IDLE : gbn_pkg::ST_ACK_UPD;
      gbn_pkg::ST_ACK_UPD: state_nxt = gbn_pkg::ST_IDLE;
      gbn_pkg::ST_TO_RD:   state_nxt = gbn_pkg::ST_TO_EMIT;
      gbn_pkg::ST_TO_EMIT: begin
        state_nxt = (rem_r == SEQ_W'(1)) ? gbn_pkg::ST_IDLE : gbn_pkg::ST_TO_RD;
      end
      default:             state_nxt = gbn_pkg::ST_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    unit_op   = gbn_pkg::OP_SUB;
    unit_a    = next_r;
    unit_b    = base_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    emit      = 1'b0;
    res       = '0;
    base_nxt  = base_r;
    next_nxt  = next_r;
    cnt_nxt   = cnt_r;
    dist_nxt  = dist_r;
    ptr_nxt   = ptr_r;
    seq_nxt   = seq_r;
    rem_nxt   = rem_r;
    first_nxt = first_r;
    case (state_r)
      gbn_pkg::ST_EVAL: begin
        cnt_nxt   = unit_y;
        rem_nxt   = unit_y;
        ptr_nxt   = base_r;
        first_nxt = 1'b1;
        case (cmd_r)
          gbn_pkg::CMD_SEND: begin
            if (full_now) begin
              emit            = 1'b1;
              res.window_full = 1'b1;
              res.last        = 1'b1;
            end
          end
          gbn_pkg::CMD_ACK: begin
          end
          gbn_pkg::CMD_TIMEOUT: begin
            if (unit_y == '0) begin
              emit            = 1'b1;
              res.window_full = full_now;
              res.last        = 1'b1;
            end
          end
          default: begin
            emit            = 1'b1;
            res.window_full = full_now;
            res.last        = 1'b1;
          end
        endcase
      end
      gbn_pkg::ST_SEND: begin
        unit_op              = gbn_pkg::OP_INC;
        unit_a               = next_r;
        ram_we               = 1'b1;
        next_nxt             = unit_y;
        emit                 = 1'b1;
        res.accepted         = 1'b1;
        res.packet_valid     = 1'b1;
        res.packet_seq       = 3'(next_r);
        res.packet_payload   = pay_wide[31:0];
        res.timer_action     = (cnt_r == '0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
        res.window_full      = ((8'(cnt_r) + 8'd1) >= eff_w);
        res.last             = 1'b1;
      end
      gbn_pkg::ST_ACK_CHK: begin
        unit_a   = ack_seq;
        dist_nxt = unit_y;
        if (ack_bad) begin
          emit            = 1'b1;
          res.window_full = full_cur;
          res.last        = 1'b1;
        end
      end
      gbn_pkg::ST_ACK_UPD: begin
        unit_op          = gbn_pkg::OP_INC;
        unit_a           = ack_seq;
        base_nxt         = unit_y;
        emit             = 1'b1;
        res.accepted     = 1'b1;
        res.timer_action = (newcnt == '0) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
        res.window_full  = (8'(newcnt) >= eff_w);
        res.last         = 1'b1;
      end
      gbn_pkg::ST_TO_RD: begin
        unit_op = gbn_pkg::OP_INC;
        unit_a  = ptr_r;
        ram_re  = 1'b1;
        seq_nxt = ptr_r;
        ptr_nxt = unit_y;
      end
      gbn_pkg::ST_TO_EMIT: begin
        emit               = 1'b1;
        res.packet_valid   = 1'b1;
        res.packet_seq     = 3'(seq_r);
        res.packet_payload = rd_wide[31:0];
        res.timer_action   = first_r ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
        res.window_full    = full_cur;
        res.last           = (rem_r == SEQ_W'(1));
        rem_nxt            = rem_r - SEQ_W'(1);
        first_nxt          = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbn_pkg::ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      wsize_r     <= gbn_pkg::WIN_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) begin
        wsize_r <= cfg_window_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    dist_r  <= dist_nxt;
    ptr_r   <= ptr_nxt;
    seq_r   <= seq_nxt;
    rem_r   <= rem_nxt;
    first_r <= first_nxt;
    if (start && !busy) begin
      cmd_r <= in_cmd;
      pay_r <= in_wide[PAYLOAD_BITS-1:0];
      ack_r <= in_ack_number;
      ok_r  <= in_ack_checksum_ok;
    end
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_res_r.accepted;
  assign out_packet_valid   = out_res_r.packet_valid;
  assign out_packet_seq     = out_res_r.packet_seq;
  assign out_packet_payload = out_res_r.packet_payload;
  assign out_timer_action   = out_res_r.timer_action;
  assign out_window_full    = out_res_r.window_full;
  assign out_last           = out_res_r.last;

  `GBN_ASSERT_NXT(a_busy_after_transfer, start && !busy, busy)
  `GBN_ASSERT_IMP(a_emit_has_work, state_r == gbn_pkg::ST_TO_EMIT, rem_r != '0)
  `GBN_ASSERT_IMP(a_resend_not_accepted,
    out_valid && out_packet_valid && out_timer_action == gbn_pkg::TMR_RESTART,
    !out_accepted)

endmodule
